/* sv/pcfd_pkg.sv */
// Shared types and constants for the polynomial cost and flip delta evaluator.
// Depends on nothing; imported by pubo_cost_and_flip_delta_top.
`timescale 1ns / 1ps

package pcfd_pkg;

	// Default sizes of the variable set and the term table.
	localparam int NUM_VARS_DEF  = 64;
	localparam int MAX_TERMS_DEF = 256;

	// Fixed field widths of the ports.
	localparam int CMD_W    = 3;
	localparam int SLOT_W   = 8;
	localparam int MEMB_W   = 64;
	localparam int WEIGHT_W = 32;
	localparam int VAR_W    = 6;
	localparam int COUNT_W  = 9;
	localparam int RESULT_W = 40;

	// Saturation limits of the signed result.
	localparam logic signed [RESULT_W-1:0] RESULT_MAX = 40'sh7F_FFFF_FFFF;
	localparam logic signed [RESULT_W-1:0] RESULT_MIN = 40'sh80_0000_0000;

	// Command codes; the remaining codes change nothing and return zero.
	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE_TERM = 3'd0,
		CMD_WRITE_SPIN = 3'd1,
		CMD_TOTAL_COST = 3'd2,
		CMD_FLIP_DELTA = 3'd3,
		CMD_APPLY_FLIP = 3'd4
	} cmd_t;

endpackage

/* sv/pubo_cost_and_flip_delta_top.sv */
// Polynomial binary objective evaluator: term table, spin register, cost and delta sequencer.
// Depends on pcfd_pkg for field widths, command codes and saturation limits.
`timescale 1ns / 1ps
// Sequence: a cost query, or a delta query on a valid variable, walks the active terms in
// ST_RUN and then registers its result in ST_FINISH; every other command goes straight to
// ST_FINISH and gives zero. The input stalls outside ST_IDLE: one table read port and one
// mask test and accumulate unit walk the terms, so a command waits until the last result is registered.
// Reset: arst_n clears the spin bits, the term count and all control state; the term table
// holds no reset value and must be written before its slots are counted in.

module pubo_cost_and_flip_delta_top #(
	parameter int NUM_VARS  = pcfd_pkg::NUM_VARS_DEF,
	parameter int MAX_TERMS = pcfd_pkg::MAX_TERMS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write channel for term_count.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pcfd_pkg::COUNT_W-1:0]        cfg_data,
	// Input channel.
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [pcfd_pkg::CMD_W-1:0]          command,
	input  logic [pcfd_pkg::SLOT_W-1:0]         term_index,
	input  logic [pcfd_pkg::MEMB_W-1:0]         term_members,
	input  logic signed [pcfd_pkg::WEIGHT_W-1:0] term_weight,
	input  logic [pcfd_pkg::VAR_W-1:0]          variable_index,
	input  logic                                spin_value,
	// Output channel.
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [pcfd_pkg::RESULT_W-1:0] result_value
);
	import pcfd_pkg::*;

	localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CNT_W = $clog2(MAX_TERMS + 1);
	localparam int ACC_W = WEIGHT_W + 1 + CNT_W;
	localparam int SAT_W = (ACC_W > RESULT_W) ? ACC_W : RESULT_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} state_t;

	state_t                      state_q;
	logic [COUNT_W-1:0]          term_count_q;
	logic [NUM_VARS-1:0]         spin_q;
	logic [CNT_W-1:0]            num_q;
	logic [CNT_W-1:0]            iss_q;
	logic                        delta_q;
	logic [NUM_VARS-1:0]         var_bit_q;
	logic                        var_set_q;
	logic signed [ACC_W-1:0]     acc_q;
	logic                        out_valid_q;
	logic signed [RESULT_W-1:0]  result_q;

	logic [NUM_VARS-1:0]         mem_mask_q [MAX_TERMS];
	logic signed [WEIGHT_W-1:0]  mem_weight_q [MAX_TERMS];
	logic [NUM_VARS-1:0]         rd_mask_s1;
	logic signed [WEIGHT_W-1:0]  rd_weight_s1;
	logic                        rd_vld_s1;

	logic                        in_xfer;
	logic                        slot_ok;
	logic                        var_ok;
	logic [NUM_VARS-1:0]         in_bit;
	logic [CNT_W-1:0]            active_num;
	logic                        rd_en;
	logic [IDX_W-1:0]            rd_addr;
	logic                        term_hit;
	logic signed [ACC_W-1:0]     weight_ext;
	logic signed [ACC_W-1:0]     addend;
	logic signed [SAT_W-1:0]     acc_ext;
	logic signed [RESULT_W-1:0]  acc_sat;
	logic                        out_free;

	assign cfg_ready    = 1'b1;
	assign in_stall     = (state_q != ST_IDLE);
	assign in_xfer      = in_valid && !in_stall;
	assign out_valid    = out_valid_q;
	assign result_value = result_q;

	// Decode of the incoming slot and variable.
	assign slot_ok    = (32'(term_index) < MAX_TERMS);
	assign var_ok     = (32'(variable_index) < NUM_VARS);
	assign in_bit     = {{(NUM_VARS-1){1'b0}}, 1'b1} << variable_index;
	assign active_num = (32'(term_count_q) > MAX_TERMS) ? CNT_W'(MAX_TERMS)
	                                                    : CNT_W'(term_count_q);

	// One table read per cycle while terms remain to be issued.
	assign rd_en   = (state_q == ST_RUN) && (iss_q != num_q);
	assign rd_addr = iss_q[IDX_W-1:0];

	// Term table write on a write term transfer.
	always_ff @(posedge clk) begin
		if (in_xfer && (cmd_t'(command) == CMD_WRITE_TERM) && slot_ok) begin
			mem_mask_q[IDX_W'(term_index)]   <= term_members[NUM_VARS-1:0];
			mem_weight_q[IDX_W'(term_index)] <= term_weight;
		end
	end

	// Registered table read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_mask_s1   <= mem_mask_q[rd_addr];
			rd_weight_s1 <= mem_weight_q[rd_addr];
		end
	end

	// Mask test and signed addend for the term that was read last cycle.
	always_comb begin
		weight_ext = ACC_W'(rd_weight_s1);
		if (delta_q) begin
			term_hit = ((rd_mask_s1 & var_bit_q) != '0)
			        && ((rd_mask_s1 & ~var_bit_q & spin_q) == '0);
			addend   = var_set_q ? weight_ext : -weight_ext;
		end else begin
			term_hit = ((rd_mask_s1 & spin_q) == '0);
			addend   = weight_ext;
		end
	end

	// Saturation of the final sum to the result range.
	always_comb begin
		acc_ext = SAT_W'(acc_q);
		if (acc_ext > SAT_W'(RESULT_MAX)) begin
			acc_sat = RESULT_MAX;
		end else if (acc_ext < SAT_W'(RESULT_MIN)) begin
			acc_sat = RESULT_MIN;
		end else begin
			acc_sat = RESULT_W'(acc_ext);
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	// Sequencer, configuration, spin register and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			term_count_q <= '0;
			spin_q       <= '0;
			num_q        <= '0;
			iss_q        <= '0;
			rd_vld_s1    <= 1'b0;
			out_valid_q  <= 1'b0;
			delta_q      <= 1'b0;
			var_bit_q    <= '0;
			var_set_q    <= 1'b0;
			acc_q        <= '0;
			result_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				term_count_q <= cfg_data;
			end

			// A waiting result leaves on its transfer.
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						acc_q     <= '0;
						iss_q     <= '0;
						rd_vld_s1 <= 1'b0;
						num_q     <= active_num;
						var_bit_q <= in_bit;
						var_set_q <= ((spin_q & in_bit) != '0);
						delta_q   <= 1'b0;
						state_q   <= ST_FINISH;
						unique case (cmd_t'(command))
							CMD_WRITE_SPIN: begin
								if (var_ok) begin
									spin_q <= spin_value ? (spin_q | in_bit)
									                     : (spin_q & ~in_bit);
								end
							end
							CMD_APPLY_FLIP: begin
								if (var_ok) begin
									spin_q <= spin_q ^ in_bit;
								end
							end
							CMD_TOTAL_COST: begin
								state_q <= ST_RUN;
							end
							CMD_FLIP_DELTA: begin
								delta_q <= 1'b1;
								if (var_ok) begin
									state_q <= ST_RUN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_RUN: begin
					rd_vld_s1 <= rd_en;
					if (rd_en) begin
						iss_q <= iss_q + 1'b1;
					end
					if (rd_vld_s1 && term_hit) begin
						acc_q <= acc_q + addend;
					end
					if (iss_q == num_q) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						result_q    <= acc_sat;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* dv/pubo_cost_and_flip_delta_top_test.sv */
// Self-checking testbench for pubo_cost_and_flip_delta_top: directed rows, then random phases.
// Depends on pcfd_pkg and the top level; holds its own model of the term table and spin bits.
`timescale 1ns / 1ps

module pubo_cost_and_flip_delta_top_test;
	import pcfd_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int TIMEOUT_CYCLES = 3_000_000;
	localparam int TAIL_CYCLES    = MAX_TERMS_DEF + 4;
	localparam int HOLD_CYCLES    = 400;
	localparam int NO_CFG         = -1;
	localparam bit KNOWN          = 1'b1;
	localparam bit PREDICT        = 1'b0;

	// Codes with no operation behind them.
	localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

	localparam logic [MEMB_W-1:0] ALL_VARS = '1;
	localparam logic [MEMB_W-1:0] VAR0     = 64'h0000_0000_0000_0001;
	localparam logic [MEMB_W-1:0] VAR63    = 64'h8000_0000_0000_0000;
	localparam logic signed [WEIGHT_W-1:0] W_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [WEIGHT_W-1:0] W_MIN = 32'sh8000_0000;
	localparam logic signed [WEIGHT_W-1:0] W_ONE = 32'sh0001_0000;

	// Random phases: term count, sender idle and receiver stall percentages, item count.
	localparam int PHASES = 7;
	localparam int PHASE_COUNT [PHASES] = '{5, 256, 17, 511, 1, 100, 0};
	localparam int PHASE_SEND  [PHASES] = '{0, 45, 0, 20, 45, 0, 20};
	localparam int PHASE_RECV  [PHASES] = '{0, 0, 45, 20, 0, 45, 20};
	localparam int PHASE_ITEMS [PHASES] = '{50, 45, 50, 45, 40, 45, 35};

	typedef struct packed {
		logic [CMD_W-1:0]           command;
		logic [SLOT_W-1:0]          slot;
		logic [MEMB_W-1:0]          members;
		logic signed [WEIGHT_W-1:0] weight;
		logic [VAR_W-1:0]           var_idx;
		logic                       spin;
	} op_t;

	typedef struct {
		int                         cfg;
		op_t                        op;
		bit                         known;
		logic signed [RESULT_W-1:0] value;
	} dir_row_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [COUNT_W-1:0]           cfg_data = '0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [CMD_W-1:0]             command = '0;
	logic [SLOT_W-1:0]            term_index = '0;
	logic [MEMB_W-1:0]            term_members = '0;
	logic signed [WEIGHT_W-1:0]   term_weight = '0;
	logic [VAR_W-1:0]             variable_index = '0;
	logic                         spin_value = 1'b0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic signed [RESULT_W-1:0]   result_value;

	// Model state of the evaluator.
	logic [MEMB_W-1:0]            model_spins = '0;
	logic [COUNT_W-1:0]           model_count = '0;
	logic [MEMB_W-1:0]            model_masks [MAX_TERMS_DEF];
	logic signed [WEIGHT_W-1:0]   model_weights [MAX_TERMS_DEF];

	logic signed [RESULT_W-1:0]   expected_values [$];
	dir_row_t                     dir_rows [$];
	int                           mismatches = 0;
	int                           send_idle_pct = 0;
	int                           recv_stall_pct = 0;
	int                           hold_req = 0;

	pubo_cost_and_flip_delta_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.term_index    (term_index),
		.term_members  (term_members),
		.term_weight   (term_weight),
		.variable_index(variable_index),
		.spin_value    (spin_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_value  (result_value)
	);

	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	// Applies one command to the model and returns the value the block must give for it.
	function automatic logic signed [RESULT_W-1:0] evaluate_command(input op_t op);
		longint            acc;
		int                active;
		logic [MEMB_W-1:0] flip_mask;
		acc = 0;
		active = (model_count > MAX_TERMS_DEF) ? MAX_TERMS_DEF : int'(model_count);
		flip_mask = VAR0 << op.var_idx;
		case (op.command)
			CMD_WRITE_TERM: begin
				model_masks[op.slot] = op.members;
				model_weights[op.slot] = op.weight;
			end
			CMD_WRITE_SPIN: model_spins[op.var_idx] = op.spin;
			CMD_TOTAL_COST: begin
				for (int t = 0; t < active; t++)
					if ((model_masks[t] & model_spins) == '0)
						acc += longint'(model_weights[t]);
			end
			CMD_FLIP_DELTA: begin
				// Only terms holding the variable whose other members are all clear count.
				for (int t = 0; t < active; t++)
					if ((model_masks[t] & flip_mask) != '0 &&
							(model_masks[t] & ~flip_mask & model_spins) == '0) begin
						if ((model_spins & flip_mask) != '0)
							acc += longint'(model_weights[t]);
						else
							acc -= longint'(model_weights[t]);
					end
			end
			CMD_APPLY_FLIP: model_spins[op.var_idx] = ~model_spins[op.var_idx];
			default: ;
		endcase
		if (acc > longint'(RESULT_MAX))
			acc = longint'(RESULT_MAX);
		if (acc < longint'(RESULT_MIN))
			acc = longint'(RESULT_MIN);
		return acc[RESULT_W-1:0];
	endfunction

	// Mostly small member sets, so that terms stay active often; now and then a full random mask.
	function automatic logic [MEMB_W-1:0] sparse_members();
		logic [MEMB_W-1:0] m;
		m = '0;
		if ($urandom_range(7) == 0)
			m = {$urandom, $urandom};
		else
			repeat ($urandom_range(4, 0)) m[$urandom_range(MEMB_W - 1)] = 1'b1;
		return m;
	endfunction

	function automatic logic signed [WEIGHT_W-1:0] random_weight();
		case ($urandom_range(15))
			0: return W_MAX;
			1: return W_MIN;
			default: return WEIGHT_W'($urandom);
		endcase
	endfunction

	function automatic op_t random_op();
		op_t op;
		int  pick;
		pick = $urandom_range(99);
		op.slot = SLOT_W'($urandom);
		op.members = sparse_members();
		op.weight = random_weight();
		op.var_idx = VAR_W'($urandom);
		op.spin = 1'($urandom);
		if (pick < 25)
			op.command = CMD_WRITE_TERM;
		else if (pick < 40)
			op.command = CMD_WRITE_SPIN;
		else if (pick < 60)
			op.command = CMD_TOTAL_COST;
		else if (pick < 82)
			op.command = CMD_FLIP_DELTA;
		else if (pick < 95)
			op.command = CMD_APPLY_FLIP;
		else
			op.command = CMD_W'($urandom_range(CMD_RSVD7, CMD_RSVD5));
		return op;
	endfunction

	function automatic dir_row_t row(input int cfg, input logic [CMD_W-1:0] cmd,
			input logic [SLOT_W-1:0] slot, input logic [MEMB_W-1:0] members,
			input logic signed [WEIGHT_W-1:0] weight, input logic [VAR_W-1:0] vi,
			input logic spin, input bit known, input logic signed [RESULT_W-1:0] value);
		dir_row_t r;
		r.cfg = cfg;
		r.op = '{cmd, slot, members, weight, vi, spin};
		r.known = known;
		r.value = value;
		return r;
	endfunction

	// Offers one item, waits for its transfer and queues the result it must produce.
	task automatic offer(input op_t op, input bit known, input logic signed [RESULT_W-1:0] value);
		logic signed [RESULT_W-1:0] predicted;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		command <= op.command;
		term_index <= op.slot;
		term_members <= op.members;
		term_weight <= op.weight;
		variable_index <= op.var_idx;
		spin_value <= op.spin;
		do @(posedge clk); while (in_stall);
		predicted = evaluate_command(op);
		expected_values.push_back(known ? value : predicted);
	endtask

	// Stops offering and waits until every queued result has arrived.
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_values.size() != 0) @(posedge clk);
	endtask

	task automatic set_term_count(input logic [COUNT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		model_count = value;
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Check each result transfer against the oldest expected value.
	always @(posedge clk) begin
		logic signed [RESULT_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_values.size() == 0) begin
				$error("result_value: expected nothing, actual %0d", result_value);
				mismatches++;
			end else begin
				want = expected_values.pop_front();
				if (result_value !== want) begin
					$error("result_value: expected %0d, actual %0d", want, result_value);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("TEST FAILED");
		$finish;
	end

	// Stimulus: reset, directed rows, table fill, random phases.
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table and reserved codes, then extreme terms counted in and queried.
		dir_rows.push_back(row(NO_CFG, CMD_TOTAL_COST, 0, 0, 0, 0, 0, KNOWN, 0));
		dir_rows.push_back(row(NO_CFG, CMD_FLIP_DELTA, '1, ALL_VARS, -1, 63, 1, KNOWN, 0));
		dir_rows.push_back(row(NO_CFG, CMD_RSVD5, '1, ALL_VARS, -1, 63, 1, KNOWN, 0));
		dir_rows.push_back(row(NO_CFG, CMD_RSVD6, 0, 0, 0, 0, 0, KNOWN, 0));
		dir_rows.push_back(row(NO_CFG, CMD_RSVD7, '1, ALL_VARS, -1, 63, 1, KNOWN, 0));
		dir_rows.push_back(row(NO_CFG, CMD_WRITE_TERM, 0, ALL_VARS, W_MAX, 0, 0, KNOWN, 0));
		dir_rows.push_back(row(NO_CFG, CMD_WRITE_TERM, 1, 0, W_MIN, 0, 0, KNOWN, 0));
		dir_rows.push_back(row(NO_CFG, CMD_WRITE_TERM, 2, VAR0, W_ONE, 0, 0, KNOWN, 0));
		dir_rows.push_back(row(NO_CFG, CMD_WRITE_TERM, 3, VAR0 | VAR63, -W_ONE, 0, 0, KNOWN, 0));
		dir_rows.push_back(row(NO_CFG, CMD_WRITE_TERM, 255, VAR63, W_MIN, 0, 0, KNOWN, 0));
		dir_rows.push_back(row(4, CMD_TOTAL_COST, 0, 0, 0, 0, 0, PREDICT, 0));
		dir_rows.push_back(row(NO_CFG, CMD_FLIP_DELTA, 0, 0, 0, 0, 0, PREDICT, 0));
		dir_rows.push_back(row(NO_CFG, CMD_WRITE_SPIN, 0, 0, 0, 63, 1, KNOWN, 0));
		dir_rows.push_back(row(NO_CFG, CMD_TOTAL_COST, 0, 0, 0, 0, 0, PREDICT, 0));
		dir_rows.push_back(row(NO_CFG, CMD_FLIP_DELTA, 0, 0, 0, 63, 0, PREDICT, 0));
		dir_rows.push_back(row(NO_CFG, CMD_APPLY_FLIP, 0, 0, 0, 63, 0, KNOWN, 0));
		dir_rows.push_back(row(NO_CFG, CMD_WRITE_SPIN, 0, 0, 0, 0, 0, KNOWN, 0));
		dir_rows.push_back(row(NO_CFG, CMD_APPLY_FLIP, 0, 0, 0, 0, 0, KNOWN, 0));
		dir_rows.push_back(row(NO_CFG, CMD_FLIP_DELTA, 0, 0, 0, 0, 0, PREDICT, 0));
		dir_rows.push_back(row(NO_CFG, CMD_TOTAL_COST, 0, 0, 0, 0, 0, PREDICT, 0));
		dir_rows.push_back(row(0, CMD_TOTAL_COST, 0, 0, 0, 0, 0, KNOWN, 0));

		foreach (dir_rows[i]) begin
			if (dir_rows[i].cfg != NO_CFG) begin
				settle();
				set_term_count(COUNT_W'(dir_rows[i].cfg));
			end
			offer(dir_rows[i].op, dir_rows[i].known, dir_rows[i].value);
		end

		// Fill every slot so that any term count is safe to evaluate.
		for (int s = 0; s < MAX_TERMS_DEF; s++)
			offer('{CMD_WRITE_TERM, SLOT_W'(s), sparse_members(), random_weight(), 0, 0},
				PREDICT, 0);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			set_term_count(COUNT_W'(PHASE_COUNT[p]));
			send_idle_pct = PHASE_SEND[p];
			recv_stall_pct <= PHASE_RECV[p];
			// The first phase opens with a long receiver hold-off to back the block up.
			if (p == 0)
				hold_req <= hold_req + 1;
			for (int i = 0; i < PHASE_ITEMS[p]; i++) begin
				if (p == 2 && i == PHASE_ITEMS[p] / 2)
					settle();
				offer(random_op(), PREDICT, 0);
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* files.f */
sv/pcfd_pkg.sv
sv/pubo_cost_and_flip_delta_top.sv
dv/pubo_cost_and_flip_delta_top_test.sv
